FILE: hw/rtl/project_world_to_image_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the world-to-image projection block
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PROJECT_WORLD_TO_IMAGE_TOP_DEFINES_SVH
`define PROJECT_WORLD_TO_IMAGE_TOP_DEFINES_SVH

// Same-cycle implication.
`define W2I_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("w2i assertion failed");

// Next-cycle implication.
`define W2I_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("w2i assertion failed");

`endif

FILE: hw/rtl/w2i_pkg.sv
// ----------------------------------------------------------------------------
// w2i_pkg
// Types, widths and register codes of the world-to-image projection block.
// ----------------------------------------------------------------------------
`default_nettype none

package w2i_pkg;

  localparam int unsigned ENTRY_W = 20;
  localparam int unsigned REG_W   = 60;
  localparam int unsigned SCALE_W = 16;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned D_W     = 21;
  localparam int unsigned P1_W    = 41;
  localparam int unsigned ACC1_W  = 43;
  localparam int unsigned C_FRAC  = 16;
  localparam int unsigned C_W     = ACC1_W - C_FRAC;
  localparam int unsigned P2_W    = 47;
  localparam int unsigned Q_W     = 49;
  localparam int unsigned MAG_W   = 48;
  localparam int unsigned HALF_W  = MAG_W / 2;
  localparam int unsigned PP_W    = HALF_W + SCALE_W;
  localparam int unsigned DIV_W   = 64;
  localparam int unsigned QUO_W   = 33;
  localparam int unsigned OUT_W   = 32;
  localparam int unsigned ALT_SH  = 10;

  typedef enum logic [IDX_W-1:0] {
    REG_INTRINSIC_ROW0,
    REG_INTRINSIC_ROW1,
    REG_INTRINSIC_ROW2,
    REG_ROTATION_ROW0,
    REG_ROTATION_ROW1,
    REG_ROTATION_ROW2,
    REG_CAMERA_POSITION,
    REG_IMAGE_SCALE
  } cfg_reg_t;

  localparam logic [REG_W-1:0]   RST_INTRINSIC_ROW0  = 60'd256;
  localparam logic [REG_W-1:0]   RST_INTRINSIC_ROW1  = 60'd268435456;
  localparam logic [REG_W-1:0]   RST_INTRINSIC_ROW2  = 60'd281474976710656;
  localparam logic [REG_W-1:0]   RST_ROTATION_ROW0   = 60'd262144;
  localparam logic [REG_W-1:0]   RST_ROTATION_ROW1   = 60'd274877906944;
  localparam logic [REG_W-1:0]   RST_ROTATION_ROW2   = 60'd288230376151711744;
  localparam logic [REG_W-1:0]   RST_CAMERA_POSITION = 60'd0;
  localparam logic [SCALE_W-1:0] RST_IMAGE_SCALE     = 16'd256;
  localparam logic [SCALE_W-1:0] SCALE_ONE           = 16'd256;

  typedef logic [2:0][REG_W-1:0] mat_t;

  typedef struct packed {
    logic signed [ENTRY_W-1:0] world_x;
    logic signed [ENTRY_W-1:0] world_y;
    logic signed [ENTRY_W-1:0] world_z;
  } in_data_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] image_x;
    logic signed [OUT_W-1:0] image_y;
    logic                    point_valid;
  } out_data_t;

  typedef struct packed {
    logic signed [Q_W-1:0] q0;
    logic signed [Q_W-1:0] q1;
    logic signed [Q_W-1:0] q2;
  } q_vec_t;

  typedef struct packed {
    logic [DIV_W-1:0]        num;
    logic [DIV_W-1:0]        den;
    logic                    neg;
    logic                    zero;
    logic signed [OUT_W-1:0] alt;
  } div_in_t;

  function automatic logic signed [ENTRY_W-1:0] entry(input logic [REG_W-1:0] r,
                                                       input int unsigned i);
    return r[ENTRY_W*i +: ENTRY_W];
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/project_world_to_image_top.sv
// ----------------------------------------------------------------------------
// project_world_to_image_top
// Pinhole projection of world points to image coordinates.
// ----------------------------------------------------------------------------
// The block accepts one world point per cycle while in_ready is high and
// returns one transaction per point, in order. Each point passes through
// the transform, the division setup, the pipelined dividers (one quotient
// bit per stage) and the output register. An output register with a spare
// entry lets the pipeline keep taking points while a result waits; when the
// spare entry fills, in_ready drops and the whole pipeline holds.
// Configuration writes take effect at once and must only be made while no
// point is in flight.
`default_nettype none

module project_world_to_image_top import w2i_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire in_data_t         in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output out_data_t             out_data,
  input  wire logic             cfg_we,
  input  wire logic [IDX_W-1:0] cfg_index,
  input  wire logic [REG_W-1:0] cfg_wdata
);

`include "project_world_to_image_top_defines.svh"

  mat_t               intr_r;
  mat_t               rot_r;
  logic [REG_W-1:0]   cam_r;
  logic [SCALE_W-1:0] scale_r;

  logic      en;
  logic      xf_valid;
  q_vec_t    q;
  logic      nm_valid;
  div_in_t   dx;
  div_in_t   dy;
  logic      dvx_valid;
  logic      dvy_valid;
  logic signed [OUT_W-1:0] res_x;
  logic signed [OUT_W-1:0] res_y;
  logic      pv_x;
  logic      pv_y;
  out_data_t tail;
  logic      tail_valid;

  logic      out_valid_r;
  out_data_t out_data_r;
  logic      spare_valid_r;
  out_data_t spare_data_r;
  logic      take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      intr_r  <= {RST_INTRINSIC_ROW2, RST_INTRINSIC_ROW1, RST_INTRINSIC_ROW0};
      rot_r   <= {RST_ROTATION_ROW2, RST_ROTATION_ROW1, RST_ROTATION_ROW0};
      cam_r   <= RST_CAMERA_POSITION;
      scale_r <= RST_IMAGE_SCALE;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_INTRINSIC_ROW0:  intr_r[0] <= cfg_wdata;
        REG_INTRINSIC_ROW1:  intr_r[1] <= cfg_wdata;
        REG_INTRINSIC_ROW2:  intr_r[2] <= cfg_wdata;
        REG_ROTATION_ROW0:   rot_r[0]  <= cfg_wdata;
        REG_ROTATION_ROW1:   rot_r[1]  <= cfg_wdata;
        REG_ROTATION_ROW2:   rot_r[2]  <= cfg_wdata;
        REG_CAMERA_POSITION: cam_r     <= cfg_wdata;
        REG_IMAGE_SCALE:     scale_r   <= cfg_wdata[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  assign en       = !spare_valid_r;
  assign in_ready = en;

  w2i_xform u_xform (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .intr      (intr_r),
    .rot       (rot_r),
    .cam_pos   (cam_r),
    .out_valid (xf_valid),
    .q         (q)
  );

  w2i_norm u_norm (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (xf_valid),
    .q         (q),
    .scale     (scale_r),
    .out_valid (nm_valid),
    .dx        (dx),
    .dy        (dy)
  );

  w2i_div u_div_x (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (nm_valid),
    .din       (dx),
    .out_valid (dvx_valid),
    .res       (res_x),
    .pt_valid  (pv_x)
  );

  w2i_div u_div_y (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (nm_valid),
    .din       (dy),
    .out_valid (dvy_valid),
    .res       (res_y),
    .pt_valid  (pv_y)
  );

  assign tail_valid       = dvx_valid;
  assign tail.image_x     = res_x;
  assign tail.image_y     = res_y;
  assign tail.point_valid = pv_x;

  assign take = out_valid_r && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r   <= 1'b0;
      spare_valid_r <= 1'b0;
    end else if (spare_valid_r) begin
      if (take) begin
        spare_valid_r <= 1'b0;
      end
    end else if (!out_valid_r || take) begin
      out_valid_r <= tail_valid;
    end else if (tail_valid) begin
      spare_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (spare_valid_r) begin
      if (take) begin
        out_data_r <= spare_data_r;
      end
    end else if (!out_valid_r || take) begin
      out_data_r <= tail;
    end else begin
      spare_data_r <= tail;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `W2I_ASSERT_IMP(a_spare_needs_out, spare_valid_r, out_valid_r)
  `W2I_ASSERT_IMP(a_lanes_aligned, dvx_valid == dvy_valid, pv_x == pv_y || !dvx_valid)
  `W2I_ASSERT_NXT(a_spare_drains, spare_valid_r && take, out_valid_r && !spare_valid_r)
  `W2I_ASSERT_IMP(a_spare_fill, $rose(spare_valid_r), $past(out_valid_r && !out_ready))

endmodule

`default_nettype wire

FILE: hw/rtl/w2i_xform.sv
// ----------------------------------------------------------------------------
// w2i_xform
// Five-stage transform: offset by camera position, rotate, round, intrinsics.
// ----------------------------------------------------------------------------
`default_nettype none

module w2i_xform import w2i_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             en,
  input  wire logic             in_valid,
  input  wire in_data_t         in_data,
  input  wire mat_t             intr,
  input  wire mat_t             rot,
  input  wire logic [REG_W-1:0] cam_pos,
  output logic                  out_valid,
  output q_vec_t                q
);

  logic [4:0] v_r;
  logic signed [D_W-1:0]    d_r   [3];
  logic signed [D_W-1:0]    d_nxt [3];
  logic signed [P1_W-1:0]   p_r   [3][3];
  logic signed [P1_W-1:0]   p_nxt [3][3];
  logic signed [C_W-1:0]    c_r   [3];
  logic signed [C_W-1:0]    c_nxt [3];
  logic signed [P2_W-1:0]   m_r   [3][3];
  logic signed [P2_W-1:0]   m_nxt [3][3];
  logic signed [Q_W-1:0]    q_r   [3];
  logic signed [Q_W-1:0]    q_nxt [3];

  always_comb begin
    logic signed [D_W-1:0]    wv [3];
    logic signed [P1_W-1:0]   a1;
    logic signed [P1_W-1:0]   b1;
    logic signed [ACC1_W-1:0] acc;
    logic signed [P2_W-1:0]   a2;
    logic signed [P2_W-1:0]   b2;
    wv[0] = D_W'(in_data.world_x);
    wv[1] = D_W'(in_data.world_y);
    wv[2] = D_W'(in_data.world_z);
    for (int j = 0; j < 3; j++) begin
      d_nxt[j] = wv[j] - D_W'(entry(cam_pos, j));
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        a1 = P1_W'(entry(rot[j], i));
        b1 = P1_W'(d_r[j]);
        p_nxt[i][j] = a1 * b1;
      end
    end
    for (int i = 0; i < 3; i++) begin
      acc = ACC1_W'(p_r[i][0]) + ACC1_W'(p_r[i][1]) + ACC1_W'(p_r[i][2])
          + ACC1_W'(1 << (C_FRAC - 1));
      c_nxt[i] = acc[ACC1_W-1:C_FRAC];
    end
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 3; i++) begin
        a2 = P2_W'(entry(intr[k], i));
        b2 = P2_W'(c_r[i]);
        m_nxt[k][i] = a2 * b2;
      end
    end
    for (int k = 0; k < 3; k++) begin
      q_nxt[k] = Q_W'(m_r[k][0]) + Q_W'(m_r[k][1]) + Q_W'(m_r[k][2]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[3:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
      p_r <= p_nxt;
      c_r <= c_nxt;
      m_r <= m_nxt;
      q_r <= q_nxt;
    end
  end

  assign out_valid = v_r[4];
  assign q.q0 = q_r[0];
  assign q.q1 = q_r[1];
  assign q.q2 = q_r[2];

endmodule

`default_nettype wire

FILE: hw/rtl/w2i_norm.sv
// ----------------------------------------------------------------------------
// w2i_norm
// Four-stage setup of the two divisions and of the zero-w fallback values.
// ----------------------------------------------------------------------------
`default_nettype none

module w2i_norm import w2i_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               en,
  input  wire logic               in_valid,
  input  wire q_vec_t             q,
  input  wire logic [SCALE_W-1:0] scale,
  output logic                    out_valid,
  output div_in_t                 dx,
  output div_in_t                 dy
);

  localparam int unsigned RND_W = Q_W + 1;
  localparam int unsigned SH_W  = RND_W - ALT_SH;

  logic [3:0] v_r;
  logic [3:0] zero_r;
  logic [3:0] neg0_r;
  logic [3:0] neg1_r;
  logic signed [OUT_W-1:0] alt0_r [4];
  logic signed [OUT_W-1:0] alt1_r [4];
  logic [MAG_W-1:0] mag0_r [3];
  logic [MAG_W-1:0] mag1_r [3];
  logic [MAG_W-1:0] mag2_r;
  logic [SCALE_W-1:0] s_r;
  logic [PP_W-1:0] pp_lo_r;
  logic [PP_W-1:0] pp_hi_r;
  logic [DIV_W-1:0] den_r [2];
  logic [DIV_W-1:0] num0_r;
  logic [DIV_W-1:0] num1_r;

  function automatic logic signed [OUT_W-1:0] alt_val(input logic signed [Q_W-1:0] v);
    logic signed [RND_W-1:0] rnd;
    logic signed [SH_W-1:0]  sh;
    rnd = RND_W'(v) + RND_W'(1 << (ALT_SH - 1));
    sh  = rnd[RND_W-1:ALT_SH];
    if (sh > SH_W'(signed'({1'b0, {(OUT_W-1){1'b1}}}))) begin
      return {1'b0, {(OUT_W-1){1'b1}}};
    end else if (sh < -SH_W'(signed'({1'b0, 1'b1, {(OUT_W-1){1'b0}}}))) begin
      return {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      return sh[OUT_W-1:0];
    end
  endfunction

  function automatic logic [MAG_W-1:0] mag(input logic signed [Q_W-1:0] v);
    logic signed [Q_W-1:0] a;
    a = v[Q_W-1] ? -v : v;
    return a[MAG_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zero_r    <= {zero_r[2:0], (q.q2 == '0)};
      neg0_r    <= {neg0_r[2:0], q.q0[Q_W-1] ^ q.q2[Q_W-1]};
      neg1_r    <= {neg1_r[2:0], q.q1[Q_W-1] ^ q.q2[Q_W-1]};
      alt0_r[0] <= alt_val(q.q0);
      alt1_r[0] <= alt_val(q.q1);
      for (int i = 1; i < 4; i++) begin
        alt0_r[i] <= alt0_r[i-1];
        alt1_r[i] <= alt1_r[i-1];
      end
      mag0_r[0] <= mag(q.q0);
      mag1_r[0] <= mag(q.q1);
      mag2_r    <= mag(q.q2);
      s_r       <= (scale == '0) ? SCALE_ONE : scale;
      for (int i = 1; i < 3; i++) begin
        mag0_r[i] <= mag0_r[i-1];
        mag1_r[i] <= mag1_r[i-1];
      end
      pp_lo_r   <= PP_W'(mag2_r[HALF_W-1:0]) * PP_W'(s_r);
      pp_hi_r   <= PP_W'(mag2_r[MAG_W-1:HALF_W]) * PP_W'(s_r);
      den_r[0]  <= {pp_hi_r, {HALF_W{1'b0}}} + DIV_W'(pp_lo_r);
      den_r[1]  <= den_r[0];
      num0_r    <= {mag0_r[2], {SCALE_W{1'b0}}} + (den_r[0] >> 1);
      num1_r    <= {mag1_r[2], {SCALE_W{1'b0}}} + (den_r[0] >> 1);
    end
  end

  assign out_valid = v_r[3];
  assign dx.num  = num0_r;
  assign dx.den  = den_r[1];
  assign dx.neg  = neg0_r[3];
  assign dx.zero = zero_r[3];
  assign dx.alt  = alt0_r[3];
  assign dy.num  = num1_r;
  assign dy.den  = den_r[1];
  assign dy.neg  = neg1_r[3];
  assign dy.zero = zero_r[3];
  assign dy.alt  = alt1_r[3];

endmodule

`default_nettype wire

FILE: hw/rtl/w2i_div.sv
// ----------------------------------------------------------------------------
// w2i_div
// Pipelined restoring divider, one quotient bit per stage, with saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module w2i_div import w2i_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        en,
  input  wire logic        in_valid,
  input  wire div_in_t     din,
  output logic             out_valid,
  output logic signed [OUT_W-1:0] res,
  output logic             pt_valid
);

  localparam int unsigned NST  = QUO_W + 1;
  localparam int unsigned HI_W = DIV_W - QUO_W;

  logic [NST:0]            v_r;
  logic [DIV_W-1:0]        rem_r  [NST];
  logic [DIV_W-1:0]        rem_nxt[NST];
  logic [QUO_W-1:0]        quo_r  [NST];
  logic [QUO_W-1:0]        quo_nxt[NST];
  logic [QUO_W-1:0]        nlo_r  [NST];
  logic [DIV_W-1:0]        den_r  [NST];
  logic                    neg_r  [NST];
  logic                    zero_r [NST];
  logic                    ovf_r  [NST];
  logic signed [OUT_W-1:0] alt_r  [NST];
  logic signed [OUT_W-1:0] res_r;
  logic signed [OUT_W-1:0] res_nxt;
  logic                    pv_r;

  always_comb begin
    logic [DIV_W:0] trial;
    logic           ge;
    rem_nxt[0] = DIV_W'(din.num[DIV_W-1:QUO_W]);
    quo_nxt[0] = '0;
    for (int s = 0; s < QUO_W; s++) begin
      trial = {rem_r[s], nlo_r[s][QUO_W-1-s]};
      ge    = (trial >= {1'b0, den_r[s]});
      rem_nxt[s+1] = ge ? DIV_W'(trial - {1'b0, den_r[s]}) : trial[DIV_W-1:0];
      quo_nxt[s+1] = {quo_r[s][QUO_W-2:0], ge};
    end
  end

  always_comb begin
    logic [QUO_W-1:0] qm;
    logic [QUO_W-1:0] qn;
    logic             big;
    qm  = quo_r[NST-1];
    qn  = '0 - qm;
    big = ovf_r[NST-1] ||
          (neg_r[NST-1] ? (qm > {2'b01, {(OUT_W-1){1'b0}}})
                        : (qm > {2'b00, {(OUT_W-1){1'b1}}}));
    if (zero_r[NST-1]) begin
      res_nxt = alt_r[NST-1];
    end else if (big) begin
      res_nxt = neg_r[NST-1] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
    end else begin
      res_nxt = neg_r[NST-1] ? qn[OUT_W-1:0] : qm[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NST-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= rem_nxt[0];
      quo_r[0]  <= quo_nxt[0];
      nlo_r[0]  <= din.num[QUO_W-1:0];
      den_r[0]  <= din.den;
      neg_r[0]  <= din.neg;
      zero_r[0] <= din.zero;
      alt_r[0]  <= din.alt;
      ovf_r[0]  <= ({{QUO_W{1'b0}}, din.num[DIV_W-1:QUO_W]} >= din.den);
      for (int s = 1; s < NST; s++) begin
        rem_r[s]  <= rem_nxt[s];
        quo_r[s]  <= quo_nxt[s];
        nlo_r[s]  <= nlo_r[s-1];
        den_r[s]  <= den_r[s-1];
        neg_r[s]  <= neg_r[s-1];
        zero_r[s] <= zero_r[s-1];
        alt_r[s]  <= alt_r[s-1];
        ovf_r[s]  <= ovf_r[s-1];
      end
      res_r <= res_nxt;
      pv_r  <= !zero_r[NST-1];
    end
  end

  assign out_valid = v_r[NST];
  assign res       = res_r;
  assign pt_valid  = pv_r;

endmodule

`default_nettype wire

FILE: tb/project_world_to_image_checker.sv
// ----------------------------------------------------------------------------
// Projection checker
// Watches the point and image channels and the register port of the
// world-to-image block, predicts each image transaction and compares it as a
// whole with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module project_world_to_image_checker import w2i_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  input  wire logic             in_ready,
  input  wire in_data_t         in_data,
  input  wire logic             out_valid,
  input  wire logic             out_ready,
  input  wire out_data_t        out_data,
  input  wire logic             cfg_we,
  input  wire logic [IDX_W-1:0] cfg_index,
  input  wire logic [REG_W-1:0] cfg_wdata,
  output int                    fail_count,
  output int                    pending_count
);

  logic [REG_W-1:0] cam_regs [8];
  out_data_t        image_queue [$];

  function automatic longint field_of(input logic [REG_W-1:0] r, input int i);
    logic signed [ENTRY_W-1:0] e;
    e = r[ENTRY_W*i +: ENTRY_W];
    return longint'(e);
  endfunction

  function automatic longint round_shift(input longint v, input int sh);
    return (v + (longint'(1) <<< (sh - 1))) >>> sh;
  endfunction

  function automatic logic [OUT_W-1:0] clamp32(input longint v);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[OUT_W-1:0];
  endfunction

  function automatic longint round_divide(input longint num, input longint den);
    logic   neg;
    longint n;
    longint d;
    longint quo;
    neg = (num < 0) != (den < 0);
    n = num < 0 ? -num : num;
    d = den < 0 ? -den : den;
    quo = (n + d / 2) / d;
    if (quo > 64'sh7FFFFFFFFFFF) quo = 64'sh7FFFFFFFFFFF;
    return neg ? -quo : quo;
  endfunction

  function automatic out_data_t project_point(input in_data_t p);
    longint    d [3];
    longint    c [3];
    longint    q [3];
    longint    s;
    longint    acc;
    out_data_t r;
    d[0] = longint'(p.world_x) - field_of(cam_regs[REG_CAMERA_POSITION], 0);
    d[1] = longint'(p.world_y) - field_of(cam_regs[REG_CAMERA_POSITION], 1);
    d[2] = longint'(p.world_z) - field_of(cam_regs[REG_CAMERA_POSITION], 2);
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int j = 0; j < 3; j++) acc += field_of(cam_regs[REG_ROTATION_ROW0 + j], i) * d[j];
      c[i] = round_shift(acc, 16);
    end
    for (int k = 0; k < 3; k++) begin
      acc = 0;
      for (int i = 0; i < 3; i++) acc += field_of(cam_regs[REG_INTRINSIC_ROW0 + k], i) * c[i];
      q[k] = acc;
    end
    if (q[2] == 0) begin
      r.image_x = clamp32(round_shift(q[0], 10));
      r.image_y = clamp32(round_shift(q[1], 10));
      r.point_valid = 1'b0;
    end else begin
      s = longint'(cam_regs[REG_IMAGE_SCALE][SCALE_W-1:0]);
      if (s == 0) s = 256;
      r.image_x = clamp32(round_divide(q[0] * 65536, q[2] * s));
      r.image_y = clamp32(round_divide(q[1] * 65536, q[2] * s));
      r.point_valid = 1'b1;
    end
    return r;
  endfunction

  assign pending_count = image_queue.size();

  always @(posedge clk) begin
    out_data_t want;
    if (!rst_n) begin
      fail_count = 0;
      cam_regs[REG_INTRINSIC_ROW0]  = RST_INTRINSIC_ROW0;
      cam_regs[REG_INTRINSIC_ROW1]  = RST_INTRINSIC_ROW1;
      cam_regs[REG_INTRINSIC_ROW2]  = RST_INTRINSIC_ROW2;
      cam_regs[REG_ROTATION_ROW0]   = RST_ROTATION_ROW0;
      cam_regs[REG_ROTATION_ROW1]   = RST_ROTATION_ROW1;
      cam_regs[REG_ROTATION_ROW2]   = RST_ROTATION_ROW2;
      cam_regs[REG_CAMERA_POSITION] = RST_CAMERA_POSITION;
      cam_regs[REG_IMAGE_SCALE]     = REG_W'(RST_IMAGE_SCALE);
    end else begin
      if (out_valid && out_ready) begin
        if (image_queue.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("Unexpected image transaction %p", out_data);
        end else begin
          want = image_queue.pop_front();
          if (want !== out_data) begin
            fail_count++;
            if (fail_count <= 10) $display("Mismatch: expected %p, got %p", want, out_data);
          end
        end
      end
      if (in_valid && in_ready) image_queue.push_back(project_point(in_data));
      if (cfg_we) begin
        if (cfg_index == REG_IMAGE_SCALE) cam_regs[cfg_index] = {44'd0, cfg_wdata[SCALE_W-1:0]};
        else cam_regs[cfg_index] = cfg_wdata;
      end
    end
  end

endmodule

`default_nettype wire

FILE: tb/tb_project_world_to_image_top.sv
// ----------------------------------------------------------------------------
// World-to-image projection testbench
// Drives directed and random world points through several camera setups with
// random gaps on both channels and a long output stall; a checker predicts and
// compares every image transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_project_world_to_image_top;
  import w2i_pkg::*;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  in_data_t         in_data = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_data_t        out_data;
  logic             cfg_we = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [REG_W-1:0] cfg_wdata = '0;
  int               fail_count;
  int               pending_count;
  int               send_idle_pct = 0;
  int               recv_idle_pct = 0;
  int               hold_cycles = 0;

  always #4 clk = ~clk;

  project_world_to_image_top DUT (.*);

  project_world_to_image_checker checker_i (.*);

  function automatic logic [ENTRY_W-1:0] pick_coord();
    case ($urandom_range(0, 5))
      0: return 20'h7FFFF;
      1: return 20'h80000;
      2: return 20'($signed($urandom_range(0, 4000)) - 2000);
      default: return 20'($urandom);
    endcase
  endfunction

  task automatic send_point(input logic [ENTRY_W-1:0] x, input logic [ENTRY_W-1:0] y,
                            input logic [ENTRY_W-1:0] z);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{world_x: x, world_y: y, world_z: z};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [REG_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
  endtask

  task automatic drain_pipeline();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (pending_count != 0 && guard < 200000) begin
      @(negedge clk);
      guard++;
    end
    repeat (60) @(negedge clk);
  endtask

  function automatic logic [REG_W-1:0] three_fields(input int a, input int b, input int c);
    return {20'(c), 20'(b), 20'(a)};
  endfunction

  task automatic load_camera(input int setup);
    case (setup)
      0: begin
        write_reg(REG_INTRINSIC_ROW0, three_fields(256 * 500, 0, 256 * 320));
        write_reg(REG_INTRINSIC_ROW1, three_fields(0, 256 * 500, 256 * 240));
        write_reg(REG_INTRINSIC_ROW2, three_fields(0, 0, 256));
        write_reg(REG_ROTATION_ROW0, three_fields(262144, 0, 0));
        write_reg(REG_ROTATION_ROW1, three_fields(0, 262144, 0));
        write_reg(REG_ROTATION_ROW2, three_fields(0, 0, 262144));
        write_reg(REG_CAMERA_POSITION, three_fields(100, -200, -2560));
        write_reg(REG_IMAGE_SCALE, 60'd512);
      end
      1: begin
        write_reg(REG_INTRINSIC_ROW0, {3{20'h7FFFF}});
        write_reg(REG_INTRINSIC_ROW1, {3{20'h80000}});
        write_reg(REG_INTRINSIC_ROW2, three_fields(1, -1, 1));
        write_reg(REG_ROTATION_ROW0, {3{20'h7FFFF}});
        write_reg(REG_ROTATION_ROW1, {3{20'h80000}});
        write_reg(REG_ROTATION_ROW2, three_fields(262144, 0, -262144));
        write_reg(REG_CAMERA_POSITION, {20'h80000, 20'h7FFFF, 20'h80000});
        write_reg(REG_IMAGE_SCALE, 60'd0);
      end
      2: begin
        write_reg(REG_INTRINSIC_ROW2, 60'd0);
        write_reg(REG_IMAGE_SCALE, 60'hFFFF);
      end
      3: begin
        for (int r = 0; r < 7; r++) write_reg(cfg_reg_t'(r), REG_W'({$urandom, $urandom}));
        write_reg(REG_IMAGE_SCALE, 60'd1);
      end
      default: begin
        for (int r = 0; r < 3; r++)
          write_reg(cfg_reg_t'(r), three_fields($urandom_range(0, 2000) - 1000,
                                                $urandom_range(0, 2000) - 1000,
                                                $urandom_range(0, 2000) - 1000));
        for (int r = 3; r < 6; r++) write_reg(cfg_reg_t'(r), REG_W'({$urandom, $urandom}));
        write_reg(REG_CAMERA_POSITION, three_fields($urandom_range(0, 20000) - 10000,
                                                    $urandom_range(0, 20000) - 10000,
                                                    $urandom_range(0, 20000) - 10000));
        write_reg(REG_IMAGE_SCALE, 60'($urandom_range(1, 65535)));
      end
    endcase
    cfg_we <= 1'b0;
  endtask

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  initial begin
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_point(20'h0, 20'h0, 20'h0);
    send_point(20'h7FFFF, 20'h7FFFF, 20'h7FFFF);
    send_point(20'h80000, 20'h80000, 20'h80000);
    send_point(20'h00100, 20'hFFF00, 20'h00100);
    send_point(20'h7FFFF, 20'h80000, 20'h00001);
    send_point(20'h80000, 20'h7FFFF, 20'hFFFFF);
    send_point(20'h00300, 20'h00200, 20'h00000);
    drain_pipeline();
    for (int s = 0; s < 3; s++) begin
      load_camera(s);
      send_point(20'h0, 20'h0, 20'h0);
      send_point(20'h7FFFF, 20'h80000, 20'h7FFFF);
      send_point(20'h80000, 20'h7FFFF, 20'h80000);
      send_point(20'h00100, 20'h00200, 20'h00A00);
      send_point(20'hFFF00, 20'h00100, 20'hFFFFF);
      drain_pipeline();
    end

    for (int ph = 0; ph < 9; ph++) begin
      send_idle_pct = ph < 3 ? 29 : (ph < 6 ? 79 : 0);
      recv_idle_pct = ph < 3 ? 79 : (ph < 6 ? 29 : 0);
      load_camera(ph == 1 ? 1 : (ph == 4 ? 3 : (ph == 7 ? 0 : 4)));
      if (ph == 6) hold_cycles <= 300;
      for (int n = 0; n < 145; n++) send_point(pick_coord(), pick_coord(), pick_coord());
      drain_pipeline();
    end

    if (fail_count == 0) begin
      $display("** project_world_to_image_top: PASSED **");
    end else begin
      $display("** project_world_to_image_top: FAILED **");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("** project_world_to_image_top: FAILED **");
    $finish;
  end

endmodule

`default_nettype wire

FILE: project_world_to_image_top.f
+incdir+hw/rtl
hw/rtl/w2i_pkg.sv
hw/rtl/w2i_xform.sv
hw/rtl/w2i_norm.sv
hw/rtl/w2i_div.sv
hw/rtl/project_world_to_image_top.sv
tb/project_world_to_image_checker.sv
tb/tb_project_world_to_image_top.sv
